### rtl/texture_slot_batch_allocator_macros.svh
// Assertion helpers for the slot batch allocator checker.
// Each macro expects clk and rst to be visible at the place of use.
`ifndef TEXTURE_SLOT_BATCH_ALLOCATOR_MACROS_SVH
`define TEXTURE_SLOT_BATCH_ALLOCATOR_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define TSBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is high.
`define TSBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tsba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsba_pkg;

  // Fixed field widths
  localparam int MODE_W    = 2;
  localparam int ID_W      = 32;
  localparam int SLOT_W    = 5;
  localparam int QUADS_W   = 13;
  localparam int FSLOTS_W  = 4;
  localparam int CAP_W     = 13;

  // Defaults for the top-level parameters
  localparam int SLOT_COUNT_DEF = 16;
  localparam int MAX_QUADS_DEF  = 4096;

  // Slot code for untextured quads and non-quad items
  localparam logic [SLOT_W-1:0] NO_SLOT = 5'd16;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd1024;

  // Reported slot count saturates here
  localparam int FSLOTS_MAX = 15;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN       = 2'd0,
    MODE_TEXTURED    = 2'd1,
    MODE_FRAME_START = 2'd2,
    MODE_FRAME_END   = 2'd3
  } mode_t;

endpackage

`default_nettype wire

### rtl/texture_slot_batch_allocator.sv
// Texture slot and quad batch bookkeeping for a sprite renderer. Each input
// transfer is one item: an untextured quad, a textured quad with its texture
// id, a frame start (clears the pending quad count) or a frame end (flushes
// the batch). Every item yields exactly one result transfer: the slot given
// to a textured quad (16 for anything else), and whether a flush happened,
// with the quad and slot counts of the flushed batch. A quad flushes first
// when the pending count has reached quad_capacity - 1 (capacity clamped to
// 2..MAX_QUADS); a new texture id flushes when SLOT_COUNT - 1 slots are in
// use. A flush only happens when quads are pending. Bound ids live in a
// SLOT_COUNT-deep synchronous RAM that is searched one entry per cycle.
// Steps: an untextured quad, frame start or frame end passes from ST_IDLE
// through ST_EMIT into the output register, and the next item is taken
// once the block is back in ST_IDLE. A textured quad whose id is new walks
// ST_SEARCH through the slots_used bound entries of the one-port id RAM in
// order (slots_used as left by any capacity flush), then is written to the
// RAM and passes through ST_EMIT into the output register. A hit on slot k
// ends the search early and goes straight to ST_EMIT. One item is in work at
// a time; a finished result sits in the output register while the next item
// is accepted, and an item whose result finds that register still full waits
// in ST_EMIT until it is free. The user must write quad_capacity through
// cfg_wr_en / cfg_wr_data only while the block is idle; the block itself
// does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module texture_slot_batch_allocator
  import tsba_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int MAX_QUADS  = MAX_QUADS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  // configuration
  input  wire                  cfg_wr_en,
  input  wire [CAP_W-1:0]      cfg_wr_data,
  // item input
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [MODE_W-1:0]     mode,
  input  wire [ID_W-1:0]       texture_id,
  // result output
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [SLOT_W-1:0]    slot,
  output logic                 flushed,
  output logic [QUADS_W-1:0]   flushed_quads,
  output logic [FSLOTS_W-1:0]  flushed_slots
);

  // Table address, slot count and quad count widths
  localparam int SW   = $clog2(SLOT_COUNT);
  localparam int SUW  = $clog2(SLOT_COUNT + 1);
  localparam int PW   = $clog2(MAX_QUADS + 1);
  localparam int CAPW = (CAP_W > PW) ? CAP_W : PW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  // Clamp a capacity to [2, MAX_QUADS] and return the flush threshold.
  function automatic logic [CAPW-1:0] cap_thresh_of(input logic [CAP_W-1:0] v);
    logic [CAPW-1:0] c;
    c = CAPW'(v);
    if (c < CAPW'(2)) begin
      c = CAPW'(2);
    end
    if (c > CAPW'(MAX_QUADS)) begin
      c = CAPW'(MAX_QUADS);
    end
    return c - CAPW'(1);
  endfunction

  // Saturate the bound slot count for reporting.
  function automatic logic [FSLOTS_W-1:0] sat_slots(input logic [SUW-1:0] v);
    if (int'(v) > FSLOTS_MAX) begin
      return FSLOTS_W'(FSLOTS_MAX);
    end
    return FSLOTS_W'(v);
  endfunction

  // Control and bookkeeping state
  state_t           state;
  logic [CAPW-1:0]  cap_thresh;
  logic [SUW-1:0]   slots_used;
  logic [PW-1:0]    quads_pending;
  logic [SUW-1:0]   idx;
  logic             cmp_pend;
  logic [SW-1:0]    cmp_slot;
  logic [ID_W-1:0]  id_reg;

  // Result being built
  logic [SLOT_W-1:0]   res_slot;
  logic                res_flushed;
  logic [PW-1:0]       res_quads;
  logic [FSLOTS_W-1:0] res_slots;

  // Id table
  logic [ID_W-1:0]  slot_mem [SLOT_COUNT];
  logic [ID_W-1:0]  mem_rdata;
  logic [SW-1:0]    mem_raddr;
  logic             mem_we;
  logic [SW-1:0]    mem_waddr;

  // Accept-side decode
  logic             in_xfer;
  logic             acc_is_quad;
  logic             acc_flush;
  logic [PW-1:0]    pend_post;
  logic [SUW-1:0]   slots_post;

  // Search-side decode
  logic             hit;
  logic             more;
  logic             nf_flush;
  logic [SUW-1:0]   s_base;
  logic [SUW-1:0]   s_wr;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Flush on accept: capacity check for quads, or a frame end.
  always_comb begin
    acc_is_quad = (mode_t'(mode) == MODE_PLAIN) || (mode_t'(mode) == MODE_TEXTURED);
    acc_flush   = (quads_pending != '0) &&
                  ((acc_is_quad && (CAPW'(quads_pending) >= cap_thresh)) ||
                   (mode_t'(mode) == MODE_FRAME_END));
    pend_post   = acc_flush ? '0 : quads_pending;
    slots_post  = acc_flush ? '0 : slots_used;
  end

  // One table entry is compared per cycle; the read issued last cycle
  // lands in mem_rdata for slot cmp_slot.
  always_comb begin
    hit       = cmp_pend && (mem_rdata == id_reg);
    more      = (idx < slots_used);
    nf_flush  = (slots_used >= SUW'(SLOT_COUNT - 1)) && (quads_pending != '0);
    s_base    = nf_flush ? '0 : slots_used;
    s_wr      = (s_base >= SUW'(SLOT_COUNT)) ? '0 : s_base;
    mem_raddr = idx[SW-1:0];
    mem_waddr = s_wr[SW-1:0];
    mem_we    = (state == ST_SEARCH) && !hit && !more;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= id_reg;
    end
    mem_rdata <= slot_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_thresh <= cap_thresh_of(CAP_RESET);
    end else if (cfg_wr_en) begin
      cap_thresh <= cap_thresh_of(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      slots_used    <= '0;
      quads_pending <= '0;
      cmp_pend      <= 1'b0;
    end else begin
      // Drop the output once the consumer takes it, unless a new result
      // moves in at the same edge.
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            id_reg      <= texture_id;
            res_slot    <= NO_SLOT;
            res_flushed <= acc_flush;
            res_quads   <= acc_flush ? quads_pending : '0;
            res_slots   <= acc_flush ? sat_slots(slots_used) : '0;
            unique case (mode_t'(mode))
              MODE_PLAIN: begin
                quads_pending <= pend_post + PW'(1);
                slots_used    <= slots_post;
                state         <= ST_EMIT;
              end
              MODE_TEXTURED: begin
                // Count the quad once the slot is known.
                quads_pending <= pend_post;
                slots_used    <= slots_post;
                idx           <= '0;
                cmp_pend      <= 1'b0;
                state         <= ST_SEARCH;
              end
              MODE_FRAME_START: begin
                quads_pending <= '0;
                state         <= ST_EMIT;
              end
              MODE_FRAME_END: begin
                quads_pending <= pend_post;
                slots_used    <= slots_post;
                state         <= ST_EMIT;
              end
            endcase
          end
        end

        ST_SEARCH: begin
          priority if (hit) begin
            res_slot      <= SLOT_W'(cmp_slot);
            quads_pending <= quads_pending + PW'(1);
            cmp_pend      <= 1'b0;
            state         <= ST_EMIT;
          end else if (more) begin
            cmp_pend <= 1'b1;
            cmp_slot <= idx[SW-1:0];
            idx      <= idx + SUW'(1);
          end else begin
            // New id: flush if the table is nearly full, wrap if full.
            if (nf_flush) begin
              res_flushed <= 1'b1;
              res_quads   <= quads_pending;
              res_slots   <= sat_slots(slots_used);
            end
            res_slot      <= SLOT_W'(s_wr);
            slots_used    <= s_wr + SUW'(1);
            quads_pending <= (nf_flush ? '0 : quads_pending) + PW'(1);
            cmp_pend      <= 1'b0;
            state         <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            slot          <= res_slot;
            flushed       <= res_flushed;
            flushed_quads <= QUADS_W'(res_quads);
            flushed_slots <= res_slots;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/tsba_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "texture_slot_batch_allocator_macros.svh"

module tsba_checker
  import tsba_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire [SLOT_W-1:0]    slot,
  input wire                 flushed,
  input wire [QUADS_W-1:0]   flushed_quads,
  input wire [FSLOTS_W-1:0]  flushed_slots
);

  // One item in work at a time.
  `TSBA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while busy")

  // A stalled result holds.
  `TSBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(slot) && $stable(flushed) && $stable(flushed_quads), "stalled result changed")

  // No flush reports zero counts.
  `TSBA_ASSERT_SAME(a_no_flush_zero, out_valid && !flushed, flushed_quads == '0 && flushed_slots == '0, "counts without flush")

  // A flush always carries pending quads.
  `TSBA_ASSERT_SAME(a_flush_quads, out_valid && flushed, flushed_quads != '0, "empty flush reported")

  // Slot is the no-slot code or a table index.
  `TSBA_ASSERT_SAME(a_slot_range, out_valid && slot != NO_SLOT, int'(slot) < SLOT_COUNT, "slot out of range")

endmodule

bind texture_slot_batch_allocator tsba_checker #(.SLOT_COUNT(SLOT_COUNT)) u_tsba_checker (.*);

`default_nettype wire
